// File: src/mcr_pkg.sv
// ----------------------------------------------------------------------------
// mcr_pkg
// Shared constants and types for the midpoint circle rasterizer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcr_pkg;

  localparam int unsigned DEC_BITS      = 20;
  localparam int unsigned OUT_BITS      = 16;
  localparam int unsigned CENTER_BITS   = 15;
  localparam int unsigned RADIUS_BITS   = 14;
  localparam int unsigned PTS_PER_GROUP = 8;
  localparam int unsigned IDX_BITS      = $clog2(PTS_PER_GROUP);
  localparam int unsigned LAST_IDX      = PTS_PER_GROUP - 1;

  typedef enum logic {
    KIND_START = 1'b0,
    KIND_STEP  = 1'b1
  } kind_e;

endpackage

`default_nettype wire

// File: src/mcr_in_if.sv
// ----------------------------------------------------------------------------
// mcr_in_if
// Command channel: start a circle or advance one iteration.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_in_if;
  logic                                    valid;
  logic                                    ready;
  logic                                    kind;
  logic signed [mcr_pkg::CENTER_BITS-1:0]  center_x;
  logic signed [mcr_pkg::CENTER_BITS-1:0]  center_y;
  logic        [mcr_pkg::RADIUS_BITS-1:0]  radius;

  modport source (output valid, kind, center_x, center_y, radius, input ready);
  modport sink   (input valid, kind, center_x, center_y, radius, output ready);
endinterface

`default_nettype wire

// File: src/mcr_out_if.sv
// ----------------------------------------------------------------------------
// mcr_out_if
// Point channel: one plotted pixel per beat.
// ----------------------------------------------------------------------------
`default_nettype none

interface mcr_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [mcr_pkg::OUT_BITS-1:0]  point_x;
  logic signed [mcr_pkg::OUT_BITS-1:0]  point_y;
  logic                                 last_of_group;
  logic                                 circle_done;

  modport source (output valid, point_x, point_y, last_of_group, circle_done,
                  input ready);
  modport sink   (input valid, point_x, point_y, last_of_group, circle_done,
                  output ready);
endinterface

`default_nettype wire

// File: src/mcr_fifo.sv
// ----------------------------------------------------------------------------
// mcr_fifo
// Small register FIFO holding group descriptors between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_fifo #(
  parameter int unsigned WIDTH = 65,
  parameter int unsigned DEPTH = 2
) (
  input  wire logic             clk_i,
  input  wire logic             rst_ni,
  input  wire logic             push_i,
  input  wire logic [WIDTH-1:0] push_data_i,
  input  wire logic             pop_i,
  output logic      [WIDTH-1:0] head_data_o,
  output logic                  full_o,
  output logic                  empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [AW-1:0]    wr_ptr_q, rd_ptr_q;
  logic [CW-1:0]    cnt_q;

  assign full_o      = (cnt_q == CW'(DEPTH));
  assign empty_o     = (cnt_q == '0);
  assign head_data_o = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == AW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == AW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   cnt_q <= cnt_q + 1'b1;
        2'b01:   cnt_q <= cnt_q - 1'b1;
        default: cnt_q <= cnt_q;
      endcase
    end
  end

`ifndef SYNTH
  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> (!full_o || pop_i))
    else $error("mcr_fifo: push while full");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !empty_o)
    else $error("mcr_fifo: pop while empty");
`endif

endmodule

`default_nettype wire

// File: src/mcr_front.sv
// ----------------------------------------------------------------------------
// mcr_front
// Accepts commands, runs the midpoint decision update and queues one
// group descriptor (centre, offsets, done flag) per productive command.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_front #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                   clk_i,
  input  wire logic                                   rst_ni,
  input  wire logic                                   in_valid_i,
  output logic                                        in_ready_o,
  input  wire logic                                   kind_i,
  input  wire logic signed [mcr_pkg::CENTER_BITS-1:0] center_x_i,
  input  wire logic signed [mcr_pkg::CENTER_BITS-1:0] center_y_i,
  input  wire logic        [mcr_pkg::RADIUS_BITS-1:0] radius_i,
  input  wire logic                                   q_full_i,
  output logic                                        push_o,
  output logic             [4*COORD_BITS:0]           push_data_o
);

  import mcr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned WB = (CB > DEC_BITS) ? CB : DEC_BITS;

  logic signed [CB-1:0]       cx_q, cy_q, x_q, y_q;
  logic signed [CB-1:0]       cx_d, cy_d, x_d, y_d;
  logic signed [DEC_BITS-1:0] d_q, d_d;
  logic                       active_q;
  logic                       accept, is_start, done;
  logic signed [CB-1:0]       x_inc, y_dec;
  logic signed [WB-1:0]       x_inc_w, y_dec_w, cx_w, cy_w;
  logic        [WB-1:0]       r_w;
  logic        [DEC_BITS-1:0] diff_dec, x_dec;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign is_start   = (kind_i == KIND_START);
  assign push_o     = accept && (is_start || active_q);

  assign x_inc    = x_q + 1'b1;
  assign y_dec    = y_q - 1'b1;
  assign x_inc_w  = WB'(x_inc);
  assign y_dec_w  = WB'(y_dec);
  assign cx_w     = WB'(center_x_i);
  assign cy_w     = WB'(center_y_i);
  assign r_w      = WB'(radius_i);
  assign diff_dec = x_inc_w[DEC_BITS-1:0] - y_dec_w[DEC_BITS-1:0];
  assign x_dec    = x_inc_w[DEC_BITS-1:0];

  always_comb begin
    cx_d = cx_q;
    cy_d = cy_q;
    x_d  = x_inc;
    y_d  = y_q;
    d_d  = d_q;
    if (is_start) begin
      cx_d = cx_w[CB-1:0];
      cy_d = cy_w[CB-1:0];
      x_d  = '0;
      y_d  = r_w[CB-1:0];
      d_d  = DEC_BITS'(3) - {r_w[DEC_BITS-2:0], 1'b0};
    end else if (d_q > 0) begin
      y_d = y_dec;
      d_d = d_q + {diff_dec[DEC_BITS-3:0], 2'b00} + DEC_BITS'(10);
    end else begin
      d_d = d_q + {x_dec[DEC_BITS-3:0], 2'b00} + DEC_BITS'(6);
    end
  end

  assign done        = (y_d < x_d);
  assign push_data_o = {cx_d, cy_d, x_d, y_d, done};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cx_q     <= '0;
      cy_q     <= '0;
      x_q      <= '0;
      y_q      <= '0;
      d_q      <= '0;
      active_q <= 1'b0;
    end else if (push_o) begin
      cx_q     <= cx_d;
      cy_q     <= cy_d;
      x_q      <= x_d;
      y_q      <= y_d;
      d_q      <= d_d;
      active_q <= !done;
    end
  end

`ifndef SYNTH
  a_active_tracks_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_o |=> (active_q == !$past(done)))
    else $error("mcr_front: active flag does not follow group end");
  a_idle_step_no_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept && !is_start && !active_q) |=> $stable(x_q) && $stable(d_q))
    else $error("mcr_front: idle step changed state");
`endif

endmodule

`default_nettype wire

// File: src/mcr_back.sv
// ----------------------------------------------------------------------------
// mcr_back
// Expands one queued group into eight mirrored points, one per beat,
// through a registered output stage.
// ----------------------------------------------------------------------------
`default_nettype none

module mcr_back #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic        [4*COORD_BITS:0]        head_data_i,
  input  wire logic                                q_empty_i,
  output logic                                     pop_o,
  output logic                                     out_valid_o,
  input  wire logic                                out_ready_i,
  output logic signed      [mcr_pkg::OUT_BITS-1:0] point_x_o,
  output logic signed      [mcr_pkg::OUT_BITS-1:0] point_y_o,
  output logic                                     last_of_group_o,
  output logic                                     circle_done_o
);

  import mcr_pkg::*;

  localparam int unsigned CB = COORD_BITS;
  localparam int unsigned WO = (CB > OUT_BITS) ? CB : OUT_BITS;

  logic signed [CB-1:0]       cx, cy, ox, oy, a, b, px, py;
  logic signed [WO-1:0]       px_w, py_w;
  logic                       grp_done, load, is_last;
  logic        [IDX_BITS-1:0] idx_q;
  logic                       valid_q, last_q, done_q;
  logic signed [OUT_BITS-1:0] px_q, py_q;

  assign {cx, cy, ox, oy, grp_done} = head_data_i;

  // bit 2 swaps the offsets, bit 0 negates x term, bit 1 negates y term
  assign a    = idx_q[2] ? oy : ox;
  assign b    = idx_q[2] ? ox : oy;
  assign px   = idx_q[0] ? (cx - a) : (cx + a);
  assign py   = idx_q[1] ? (cy - b) : (cy + b);
  assign px_w = WO'(px);
  assign py_w = WO'(py);

  assign is_last = (idx_q == IDX_BITS'(LAST_IDX));
  assign load    = !q_empty_i && (!valid_q || out_ready_i);
  assign pop_o   = load && is_last;

  always_ff @(posedge clk_i) begin
    if (load) begin
      px_q   <= px_w[OUT_BITS-1:0];
      py_q   <= py_w[OUT_BITS-1:0];
      last_q <= is_last;
      done_q <= grp_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      idx_q   <= '0;
    end else if (load) begin
      valid_q <= 1'b1;
      idx_q   <= idx_q + 1'b1;
    end else if (out_ready_i) begin
      valid_q <= 1'b0;
    end
  end

  assign out_valid_o     = valid_q;
  assign point_x_o       = px_q;
  assign point_y_o       = py_q;
  assign last_of_group_o = last_q;
  assign circle_done_o   = done_q;

`ifndef SYNTH
  a_pop_marks_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (valid_q && last_q && (idx_q == '0)))
    else $error("mcr_back: group retired without last beat");
`endif

endmodule

`default_nettype wire

// File: src/midpoint_circle_rasterizer_unit.sv
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit
// Midpoint circle rasterizer with eight-way symmetry: front decision
// update, group queue, point emitter.
//
//   channel | dir | payload                                    | beats/item
//   in_i    | in  | kind, center_x, center_y, radius           | 1
//   out_o   | out | point_x, point_y, last_of_group, circle_done| 8 or 0
//
// A start, or a step while a circle is active, yields eight beats, one per
// cycle while the point port is ready and a group is queued.
// A step with no active circle is accepted and yields no beat.
// The front keeps taking commands while the 2-entry group queue has room;
// a group's first beat passes the queue, then the registered output stage.
// Reset clears the circle state and the queue; no warm-up pass.
// ----------------------------------------------------------------------------
`default_nettype none

module midpoint_circle_rasterizer_unit #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  mcr_in_if.sink     in_i,
  mcr_out_if.source  out_o
);

  import mcr_pkg::*;

  localparam int unsigned GW = 4 * COORD_BITS + 1;

  logic          push, pop, q_full, q_empty;
  logic [GW-1:0] push_data, head_data;

  mcr_front #(.COORD_BITS(COORD_BITS)) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .kind_i      (in_i.kind),
    .center_x_i  (in_i.center_x),
    .center_y_i  (in_i.center_y),
    .radius_i    (in_i.radius),
    .q_full_i    (q_full),
    .push_o      (push),
    .push_data_o (push_data)
  );

  mcr_fifo #(.WIDTH(GW), .DEPTH(2)) u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_data_i (push_data),
    .pop_i       (pop),
    .head_data_o (head_data),
    .full_o      (q_full),
    .empty_o     (q_empty)
  );

  mcr_back #(.COORD_BITS(COORD_BITS)) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .head_data_i     (head_data),
    .q_empty_i       (q_empty),
    .pop_o           (pop),
    .out_valid_o     (out_o.valid),
    .out_ready_i     (out_o.ready),
    .point_x_o       (out_o.point_x),
    .point_y_o       (out_o.point_y),
    .last_of_group_o (out_o.last_of_group),
    .circle_done_o   (out_o.circle_done)
  );

`ifndef SYNTH
  a_push_needs_cmd: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> (in_i.valid && in_i.ready))
    else $error("midpoint_circle_rasterizer_unit: group queued without command");
`endif

endmodule

`default_nettype wire

// File: tb/midpoint_circle_rasterizer_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// midpoint_circle_rasterizer_unit_tb
// Checks the circle rasterizer against an in-bench predictor of the midpoint
// decision loop. Each start or active-circle step is predicted into its eight
// mirrored points and every point beat is compared field by field in order.
// Stimulus is directed corner cases followed by random circles (mostly run
// to the end, some abandoned) mixed with stray steps. Both sides idle at random,
// and the point side twice holds off long enough to back up the command side.
// ----------------------------------------------------------------------------

module midpoint_circle_rasterizer_unit_tb;
  import mcr_pkg::*;

  localparam int unsigned COORD_BITS   = 16;
  localparam int unsigned ITEM_TARGET  = 410;
  localparam int unsigned HOLD_CYCLES  = 400;
  localparam int unsigned QUIET_LIMIT  = 2000;
  localparam int unsigned TAIL_CYCLES  = 40;
  localparam int unsigned MAX_PRINTS   = 30;

  typedef struct {
    kind_e                          kind;
    logic signed [CENTER_BITS-1:0]  center_x;
    logic signed [CENTER_BITS-1:0]  center_y;
    logic        [RADIUS_BITS-1:0]  radius;
  } circle_cmd_t;

  typedef struct {
    logic signed [OUT_BITS-1:0]  px;
    logic signed [OUT_BITS-1:0]  py;
    logic                        last;
    logic                        done;
  } plot_point_t;

  typedef struct {
    logic signed [COORD_BITS-1:0]  cx;
    logic signed [COORD_BITS-1:0]  cy;
    logic signed [COORD_BITS-1:0]  ox;
    logic signed [COORD_BITS-1:0]  oy;
    logic signed [DEC_BITS-1:0]    dec;
    logic                          active;
  } circle_state_t;

  logic clk_i;
  logic rst_ni;

  mcr_in_if  in_bus ();
  mcr_out_if out_bus ();

  midpoint_circle_rasterizer_unit #(
    .COORD_BITS(COORD_BITS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_bus),
    .out_o  (out_bus)
  );

  circle_cmd_t   pending_cmds [$];
  plot_point_t   pending_points [$];
  circle_state_t gen_state;
  circle_state_t dut_state;

  int unsigned productive_items;
  int unsigned total_items;
  int unsigned items_taken;
  int unsigned beats_seen;
  int unsigned errors;
  int unsigned n_starts, n_steps, n_idle_steps, n_circles;
  int unsigned quiet_cycles;

  logic        in_taken, out_taken;
  logic        drv_busy, drv_calm, rcv_calm;
  int unsigned drv_wait, rcv_wait, hold_left, holds_done;
  circle_cmd_t drv_cmd;

  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // One midpoint iteration (or a fresh start) and its eight mirrored points.
  function automatic int unsigned plot_group(inout circle_state_t st, input circle_cmd_t c,
                                             output plot_point_t pts [PTS_PER_GROUP]);
    logic done;
    for (int i = 0; i < PTS_PER_GROUP; i++) pts[i] = '{default: '0};
    if (c.kind == KIND_START) begin
      st.cx  = c.center_x;
      st.cy  = c.center_y;
      st.ox  = '0;
      st.oy  = COORD_BITS'(c.radius);
      st.dec = DEC_BITS'(3 - 2 * int'(c.radius));
    end else begin
      if (!st.active) return 0;
      st.ox = st.ox + 1;
      if (st.dec > 0) begin
        st.oy  = st.oy - 1;
        st.dec = st.dec + 4 * (st.ox - st.oy) + 10;
      end else begin
        st.dec = st.dec + 4 * st.ox + 6;
      end
    end
    done = st.oy < st.ox;
    pts[0].px = st.cx + st.ox;  pts[0].py = st.cy + st.oy;
    pts[1].px = st.cx - st.ox;  pts[1].py = st.cy + st.oy;
    pts[2].px = st.cx + st.ox;  pts[2].py = st.cy - st.oy;
    pts[3].px = st.cx - st.ox;  pts[3].py = st.cy - st.oy;
    pts[4].px = st.cx + st.oy;  pts[4].py = st.cy + st.ox;
    pts[5].px = st.cx - st.oy;  pts[5].py = st.cy + st.ox;
    pts[6].px = st.cx + st.oy;  pts[6].py = st.cy - st.ox;
    pts[7].px = st.cx - st.oy;  pts[7].py = st.cy - st.ox;
    for (int i = 0; i < PTS_PER_GROUP; i++) begin
      pts[i].done = done;
      pts[i].last = (i == LAST_IDX);
    end
    st.active = !done;
    return PTS_PER_GROUP;
  endfunction

  function automatic void add_cmd(kind_e k, int cx, int cy, int r);
    circle_cmd_t c;
    plot_point_t pts [PTS_PER_GROUP];
    c.kind     = k;
    c.center_x = CENTER_BITS'(cx);
    c.center_y = CENTER_BITS'(cy);
    c.radius   = RADIUS_BITS'(r);
    pending_cmds.insert(pending_cmds.size(), c);
    if (plot_group(gen_state, c, pts) != 0) productive_items++;
  endfunction

  function automatic void run_circle(int cx, int cy, int r, int max_steps);
    int n;
    n = 0;
    add_cmd(KIND_START, cx, cy, r);
    while (gen_state.active && n < max_steps) begin
      add_cmd(KIND_STEP, $urandom, $urandom, $urandom);
      n++;
    end
  endfunction

  task automatic report_mismatch(input string msg);
    if (errors < MAX_PRINTS) $display("%0t mismatch: %s", $realtime, msg);
    errors++;
  endtask

  // Command side: accept, predict, queue the expected points.
  always @(posedge clk_i) begin
    circle_cmd_t c;
    plot_point_t pts [PTS_PER_GROUP];
    in_taken <= rst_ni && in_bus.valid && in_bus.ready;
    if (rst_ni && in_bus.valid && in_bus.ready) begin
      c.kind     = kind_e'(in_bus.kind);
      c.center_x = in_bus.center_x;
      c.center_y = in_bus.center_y;
      c.radius   = in_bus.radius;
      items_taken++;
      if (plot_group(dut_state, c, pts) != 0) begin
        for (int i = 0; i < PTS_PER_GROUP; i++) begin
          pending_points.insert(pending_points.size(), pts[i]);
        end
        if (c.kind == KIND_START) n_starts++;
        else n_steps++;
      end else begin
        n_idle_steps++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (!drv_busy || in_taken) begin
        if (drv_wait > 0) begin
          in_bus.valid <= 1'b0;
          drv_busy     <= 1'b0;
          drv_wait     <= drv_wait - 1;
        end else if (pending_cmds.size() > 0) begin
          drv_cmd = pending_cmds.pop_front();
          in_bus.valid    <= 1'b1;
          in_bus.kind     <= drv_cmd.kind;
          in_bus.center_x <= drv_cmd.center_x;
          in_bus.center_y <= drv_cmd.center_y;
          in_bus.radius   <= drv_cmd.radius;
          drv_busy        <= 1'b1;
          if ($urandom_range(0, 15) == 0) drv_calm <= !drv_calm;
          drv_wait <= drv_calm ? 0 : $urandom_range(0, 11);
        end else begin
          in_bus.valid <= 1'b0;
          drv_busy     <= 1'b0;
        end
      end
    end
  end

  // Point side: compare each beat with the oldest expected point.
  always @(posedge clk_i) begin
    plot_point_t want;
    out_taken <= rst_ni && out_bus.valid && out_bus.ready;
    if (rst_ni && out_bus.valid && out_bus.ready) begin
      beats_seen++;
      if (pending_points.size() == 0) begin
        report_mismatch($sformatf("unexpected beat x=%0d y=%0d", out_bus.point_x,
                                  out_bus.point_y));
      end else begin
        want = pending_points.pop_front();
        if (out_bus.point_x !== want.px)
          report_mismatch($sformatf("point_x got %0d want %0d", out_bus.point_x, want.px));
        if (out_bus.point_y !== want.py)
          report_mismatch($sformatf("point_y got %0d want %0d", out_bus.point_y, want.py));
        if (out_bus.last_of_group !== want.last)
          report_mismatch($sformatf("last_of_group got %b want %b", out_bus.last_of_group,
                                    want.last));
        if (out_bus.circle_done !== want.done)
          report_mismatch($sformatf("circle_done got %b want %b", out_bus.circle_done,
                                    want.done));
        if (want.last && want.done) n_circles++;
      end
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (hold_left > 0) begin
        out_bus.ready <= 1'b0;
        hold_left     <= hold_left - 1;
      end else if (holds_done < 2 && beats_seen >= (holds_done == 0 ? 150 : 2000)) begin
        out_bus.ready <= 1'b0;
        hold_left     <= HOLD_CYCLES;
        holds_done    <= holds_done + 1;
      end else if (!out_bus.ready || out_taken) begin
        if (rcv_wait > 0) begin
          out_bus.ready <= 1'b0;
          rcv_wait      <= rcv_wait - 1;
        end else begin
          out_bus.ready <= 1'b1;
          if ($urandom_range(0, 15) == 0) rcv_calm <= !rcv_calm;
          rcv_wait <= rcv_calm ? 0 : $urandom_range(0, 11);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("timeout: no beat for %0d cycles", QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  initial begin
    int sel, rs, r, lim;
    rst_ni           = 1'b0;
    in_bus.valid     = 1'b0;
    in_bus.kind      = KIND_START;
    in_bus.center_x  = '0;
    in_bus.center_y  = '0;
    in_bus.radius    = '0;
    out_bus.ready    = 1'b0;
    in_taken         = 1'b0;
    out_taken        = 1'b0;
    drv_busy         = 1'b0;
    drv_calm         = 1'b0;
    rcv_calm         = 1'b0;
    drv_wait         = 0;
    rcv_wait         = 0;
    hold_left        = 0;
    holds_done       = 0;
    quiet_cycles     = 0;
    errors           = 0;
    items_taken      = 0;
    beats_seen       = 0;
    productive_items = 0;
    n_starts         = 0;
    n_steps          = 0;
    n_idle_steps     = 0;
    n_circles        = 0;
    gen_state        = '{default: '0};
    dut_state        = '{default: '0};

    // directed: idle step, zero radius, extremes with wrap, restart while active
    add_cmd(KIND_STEP, 0, 0, 0);
    run_circle(0, 0, 0, 4);
    add_cmd(KIND_STEP, 0, 0, 0);
    run_circle(16383, -16384, 16383, 3);
    run_circle(-16384, 16383, 1, 4);
    add_cmd(KIND_STEP, -1, -1, 16383);
    run_circle(-1, -1, 5, 10);
    run_circle('h2AAA, 'h5555, 'h2AAA, 2);
    run_circle('h5555, 'h2AAA, 'h1555, 2);
    run_circle(100, -100, 3, 1);

    while (productive_items < ITEM_TARGET) begin
      sel = $urandom_range(0, 99);
      if (sel < 8) begin
        add_cmd(KIND_STEP, $urandom, $urandom, $urandom);
      end else begin
        rs = $urandom_range(0, 99);
        if (rs < 75) r = $urandom_range(0, 20);
        else if (rs < 92) r = $urandom_range(21, 60);
        else r = $urandom_range(0, 16383);
        lim = ($urandom_range(0, 9) == 0) ? $urandom_range(0, 5) : 1 << 20;
        if (r > 60) lim = $urandom_range(0, 12);
        run_circle($urandom, $urandom, r, lim);
      end
    end
    total_items = pending_cmds.size();

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (items_taken == total_items && pending_points.size() == 0);
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (pending_points.size() != 0)
      report_mismatch($sformatf("%0d points never arrived", pending_points.size()));

    $display("covered %0d commands: %0d starts, %0d steps, %0d steps with no circle",
             items_taken, n_starts, n_steps, n_idle_steps);
    $display("checked %0d point beats, %0d circles run to the end, %0d mismatches",
             beats_seen, n_circles, errors);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
